// ===== src/cia_pkg.sv =====
package cia_pkg;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_DIV  = 4'd3;
   localparam logic [3:0] OP_REM  = 4'd4;
   localparam logic [3:0] OP_NEG  = 4'd5;
   localparam logic [3:0] OP_PLUS = 4'd6;
   localparam logic [3:0] OP_NOT  = 4'd7;
   localparam logic [3:0] OP_AND  = 4'd8;
   localparam logic [3:0] OP_OR   = 4'd9;
   localparam logic [3:0] OP_XOR  = 4'd10;
   localparam logic [3:0] OP_CMP  = 4'd11;
   localparam logic [3:0] OP_SHLC = 4'd12;
   localparam logic [3:0] OP_SHL  = 4'd13;
   localparam logic [3:0] OP_SRA  = 4'd14;
   localparam logic [3:0] OP_SRL  = 4'd15;

   localparam logic [2:0] PRED_EQ = 3'd0;
   localparam logic [2:0] PRED_NE = 3'd1;
   localparam logic [2:0] PRED_LT = 3'd2;
   localparam logic [2:0] PRED_LE = 3'd3;
   localparam logic [2:0] PRED_GT = 3'd4;

   localparam logic [1:0] RSN_NONE     = 2'd0;
   localparam logic [1:0] RSN_OVERFLOW = 2'd1;
   localparam logic [1:0] RSN_DIVZERO  = 2'd2;
   localparam logic [1:0] RSN_SHIFT    = 2'd3;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_MUL  = 2'd1,
      MODE_DIV  = 2'd2,
      MODE_REM  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       sgn;
      logic       neg_q;
      logic       neg_r;
      logic       fail;
      logic [1:0] reason;
   } ctl_type;

endpackage

// ===== src/cia_req_if.sv =====
interface cia_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  op;
   logic        is_signed;
   logic [31:0] left_operand;
   logic [31:0] right_operand;
   logic        count_is_signed;
   logic [2:0]  predicate;

   modport source (output valid, op, is_signed, left_operand, right_operand,
                   count_is_signed, predicate, input ready);
   modport sink (input valid, op, is_signed, left_operand, right_operand,
                 count_is_signed, predicate, output ready);
endinterface

// ===== src/cia_rsp_if.sv =====
interface cia_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result;
   logic        failed;
   logic [1:0]  reason;

   modport source (output valid, result, failed, reason, input ready);
   modport sink (input valid, result, failed, reason, output ready);
endinterface

// ===== src/cia_front.sv =====
module cia_front
   import cia_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic [3:0]         op,
   input  logic               is_signed,
   input  logic [31:0]        left_operand,
   input  logic [31:0]        right_operand,
   input  logic               count_is_signed,
   input  logic [2:0]         predicate,
   output ctl_type            ctl,
   output logic [WIDTH-1:0]   x,
   output logic [WIDTH-1:0]   y,
   output logic [2*WIDTH-1:0] acc
);
   localparam int CW = $clog2(WIDTH);
   localparam logic [WIDTH-1:0] SBIT = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] ONES = {WIDTH{1'b1}};

   logic [WIDTH-1:0] a, b, r, d, ma, mb, md, topmask, atop;
   logic [WIDTH:0]   sum, dif;
   logic             lt_ab, lt_ba, cv, bad, ov, dz, dov;
   logic [CW-1:0]    c;
   logic [CW:0]      c1;

   always_comb begin
      a = WIDTH'(left_operand);
      b = WIDTH'(right_operand);
      sum = {1'b0, a} + {1'b0, b};
      dif = {1'b0, a} - {1'b0, b};
      lt_ab = is_signed ? ($signed(a) < $signed(b)) : (a < b);
      lt_ba = is_signed ? ($signed(b) < $signed(a)) : (b < a);
      case (predicate)
         PRED_EQ: cv = a == b;
         PRED_NE: cv = a != b;
         PRED_LT: cv = lt_ab;
         PRED_LE: cv = !lt_ba;
         PRED_GT: cv = lt_ba;
         default: cv = !lt_ab;
      endcase
      bad = (count_is_signed && b[WIDTH-1]) || (b >= WIDTH'(WIDTH));
      c = bad ? '0 : b[CW-1:0];
      c1 = {1'b0, c} + 1'b1;
      topmask = ~(ONES >> c1);
      atop = a & topmask;
      ov = !(atop == '0 || atop == topmask);
      dz = b == '0;
      dov = is_signed && a == SBIT && b == ONES;
      d = (dz || dov) ? WIDTH'(1) : b;
      ma = (is_signed && a[WIDTH-1]) ? -a : a;
      mb = (is_signed && b[WIDTH-1]) ? -b : b;
      md = (is_signed && d[WIDTH-1]) ? -d : d;

      ctl = '0;
      ctl.mode = MODE_PASS;
      ctl.sgn = is_signed;
      x = '0;
      y = '0;
      r = '0;
      case (op)
         OP_ADD: begin
            r = sum[WIDTH-1:0];
            ctl.fail = is_signed ? (~(a[WIDTH-1] ^ b[WIDTH-1]) & (a[WIDTH-1] ^ r[WIDTH-1]))
                                 : sum[WIDTH];
         end
         OP_SUB: begin
            r = dif[WIDTH-1:0];
            ctl.fail = is_signed ? ((a[WIDTH-1] ^ b[WIDTH-1]) & (a[WIDTH-1] ^ r[WIDTH-1]))
                                 : dif[WIDTH];
         end
         OP_MUL: begin
            ctl.mode = MODE_MUL;
            x = ma;
            y = mb;
            ctl.neg_q = is_signed && (a[WIDTH-1] ^ b[WIDTH-1]);
         end
         OP_DIV, OP_REM: begin
            ctl.mode = (op == OP_DIV) ? MODE_DIV : MODE_REM;
            x = ma;
            y = md;
            ctl.neg_q = is_signed && (a[WIDTH-1] ^ d[WIDTH-1]);
            ctl.neg_r = is_signed && a[WIDTH-1];
            ctl.fail = dz || dov;
            ctl.reason = dz ? RSN_DIVZERO : (dov ? RSN_OVERFLOW : RSN_NONE);
         end
         OP_NEG: begin
            r = -a;
            ctl.fail = a == SBIT;
         end
         OP_PLUS: r = a;
         OP_NOT:  r = ~a;
         OP_AND:  r = a & b;
         OP_OR:   r = a | b;
         OP_XOR:  r = a ^ b;
         OP_CMP:  r = WIDTH'(cv);
         OP_SHLC: begin
            r = a << c;
            ctl.fail = bad || ov;
            ctl.reason = bad ? RSN_SHIFT : (ov ? RSN_OVERFLOW : RSN_NONE);
         end
         OP_SHL: begin
            r = a << c;
            ctl.fail = bad;
            ctl.reason = bad ? RSN_SHIFT : RSN_NONE;
         end
         OP_SRA: begin
            r = $signed(a) >>> c;
            ctl.fail = bad;
            ctl.reason = bad ? RSN_SHIFT : RSN_NONE;
         end
         default: begin
            r = a >> c;
            ctl.fail = bad;
            ctl.reason = bad ? RSN_SHIFT : RSN_NONE;
         end
      endcase
      if (op == OP_ADD || op == OP_SUB || op == OP_NEG) begin
         ctl.reason = ctl.fail ? RSN_OVERFLOW : RSN_NONE;
      end
      acc = {{WIDTH{1'b0}}, r};
   end
endmodule

// ===== src/cia_cell.sv =====
module cia_cell
   import cia_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ctl_type            in_ctl,
   input  logic [WIDTH-1:0]   in_x,
   input  logic [WIDTH-1:0]   in_y,
   input  logic [2*WIDTH-1:0] in_acc,
   output logic               out_valid,
   input  logic               out_ready,
   output ctl_type            out_ctl,
   output logic [WIDTH-1:0]   out_x,
   output logic [WIDTH-1:0]   out_y,
   output logic [2*WIDTH-1:0] out_acc
);
   logic               valid_ff;
   ctl_type            ctl_ff;
   logic [WIDTH-1:0]   x_ff, x_in, y_ff;
   logic [2*WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH:0]     t, t_sub;
   logic               ge;

   // one bit per cell, msb of x first: shift-add or restoring divide step
   always_comb begin
      t = {in_acc[WIDTH-1:0], in_x[WIDTH-1]};
      t_sub = t - {1'b0, in_y};
      ge = t >= {1'b0, in_y};
      x_in = in_x;
      acc_in = in_acc;
      case (in_ctl.mode)
         MODE_MUL: begin
            acc_in = {in_acc[2*WIDTH-2:0], 1'b0}
                   + (in_x[WIDTH-1] ? {{WIDTH{1'b0}}, in_y} : '0);
            x_in = {in_x[WIDTH-2:0], 1'b0};
         end
         MODE_DIV, MODE_REM: begin
            acc_in = {{WIDTH{1'b0}}, (ge ? t_sub[WIDTH-1:0] : t[WIDTH-1:0])};
            x_in = {in_x[WIDTH-2:0], ge};
         end
         default: ;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         ctl_ff <= in_ctl;
         x_ff <= x_in;
         y_ff <= in_y;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl = ctl_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_acc = acc_ff;
endmodule

// ===== src/cia_back.sv =====
module cia_back
   import cia_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ctl_type            in_ctl,
   input  logic [WIDTH-1:0]   in_x,
   input  logic [2*WIDTH-1:0] in_acc,
   cia_rsp_if.source          rsp
);
   logic             valid_ff;
   logic [31:0]      result_ff;
   logic             failed_ff;
   logic [1:0]       reason_ff;
   logic [WIDTH-1:0] lo, hi, lim, res;
   logic             fail;
   logic [1:0]       why;

   always_comb begin
      lo = in_acc[WIDTH-1:0];
      hi = in_acc[2*WIDTH-1:WIDTH];
      lim = {in_ctl.neg_q, {(WIDTH-1){~in_ctl.neg_q}}};
      res = lo;
      fail = in_ctl.fail;
      why = in_ctl.reason;
      case (in_ctl.mode)
         MODE_MUL: begin
            res = in_ctl.neg_q ? -lo : lo;
            fail = (hi != '0) || (in_ctl.sgn && lo > lim);
            why = fail ? RSN_OVERFLOW : RSN_NONE;
         end
         MODE_DIV: res = in_ctl.neg_q ? -in_x : in_x;
         MODE_REM: res = in_ctl.neg_r ? -lo : lo;
         default: ;
      endcase
   end

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         result_ff <= 32'(res);
         failed_ff <= fail;
         reason_ff <= why;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.result = result_ff;
   assign rsp.failed = failed_ff;
   assign rsp.reason = reason_ff;
endmodule

// ===== src/checked_integer_alu_unit.sv =====
// checked integer alu
// req channel: one transaction carries op, is_signed, both operands,
// count_is_signed and predicate. rsp channel: result, failed and reason.
// every operation passes through a row of WIDTH identical cells; each cell
// handles one bit of the first operand, msb first: a shift-add step for
// multiply, a restoring divide step for divide and remainder, and a plain
// hand-off for every other operation, which is finished before the row.
// each transaction is registered in every cell and then in the output register before rsp.valid.
// throughput: one transaction per cycle while rsp.ready is high, for any mix of operations.
// each cell and the output register hold one transaction and move on when
// the next stage is empty or moving, so bubbles close up and req.ready
// stays high while the row has room, also while a result waits.
// when the receiver stalls the row fills up; after WIDTH + 1 transactions
// req.ready drops until rsp.ready returns.
// reset (synchronous) empties every stage; no results are pending after it.
module checked_integer_alu_unit
   import cia_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   cia_req_if.sink   req,
   cia_rsp_if.source rsp
);
   ctl_type            ctl_w [WIDTH+1];
   logic [WIDTH-1:0]   x_w   [WIDTH+1];
   logic [WIDTH-1:0]   y_w   [WIDTH+1];
   logic [2*WIDTH-1:0] acc_w [WIDTH+1];
   logic               vld_w [WIDTH+1];
   logic               rdy_w [WIDTH+1];

   cia_front #(.WIDTH(WIDTH)) u_front (
      .op              (req.op),
      .is_signed       (req.is_signed),
      .left_operand    (req.left_operand),
      .right_operand   (req.right_operand),
      .count_is_signed (req.count_is_signed),
      .predicate       (req.predicate),
      .ctl             (ctl_w[0]),
      .x               (x_w[0]),
      .y               (y_w[0]),
      .acc             (acc_w[0])
   );

   assign vld_w[0] = req.valid;
   assign req.ready = rdy_w[0];

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      cia_cell #(.WIDTH(WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_w[i]),
         .in_ready  (rdy_w[i]),
         .in_ctl    (ctl_w[i]),
         .in_x      (x_w[i]),
         .in_y      (y_w[i]),
         .in_acc    (acc_w[i]),
         .out_valid (vld_w[i+1]),
         .out_ready (rdy_w[i+1]),
         .out_ctl   (ctl_w[i+1]),
         .out_x     (x_w[i+1]),
         .out_y     (y_w[i+1]),
         .out_acc   (acc_w[i+1])
      );
   end

   cia_back #(.WIDTH(WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (vld_w[WIDTH]),
      .in_ready (rdy_w[WIDTH]),
      .in_ctl   (ctl_w[WIDTH]),
      .in_x     (x_w[WIDTH]),
      .in_acc   (acc_w[WIDTH]),
      .rsp      (rsp)
   );
endmodule

// ===== tb/sv/tb_checked_integer_alu_unit.sv =====
`timescale 1ns / 100ps

module tb_checked_integer_alu_unit;
   import cia_pkg::*;

   localparam int W = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct packed {
      logic [3:0]  op;
      logic        sgn;
      logic [31:0] a;
      logic [31:0] b;
      logic        csgn;
      logic [2:0]  pred;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        failed;
      logic [1:0]  reason;
   } alu_rsp_type;

   function automatic alu_rsp_type compute_alu(alu_req_type t);
      alu_rsp_type o;
      logic [63:0] wa, wb, p;
      logic signed [64:0] sp;
      logic [31:0] d, ma, md, q;
      logic dz, ov, bad, lt, gt, v;
      int c;
      o = '0;
      wa = {32'd0, t.a};
      wb = {32'd0, t.b};
      case (t.op)
         OP_ADD: begin
            o.result = t.a + t.b;
            if (t.sgn) o.failed = ~(t.a[31] ^ t.b[31]) & (t.a[31] ^ o.result[31]);
            else o.failed = o.result < t.a;
         end
         OP_SUB: begin
            o.result = t.a - t.b;
            if (t.sgn) o.failed = (t.a[31] ^ t.b[31]) & (t.a[31] ^ o.result[31]);
            else o.failed = t.a < t.b;
         end
         OP_MUL: begin
            o.result = t.a * t.b;
            if (t.sgn) begin
               sp = $signed({{33{t.a[31]}}, t.a}) * $signed({{33{t.b[31]}}, t.b});
               o.failed = (sp > 65'sd2147483647) || (sp < -65'sd2147483648);
            end else begin
               p = wa * wb;
               o.failed = p[63:32] != 0;
            end
         end
         OP_DIV, OP_REM: begin
            dz = t.b == 0;
            ov = t.sgn && t.a == 32'h8000_0000 && t.b == 32'hffff_ffff;
            d = (dz || ov) ? 32'd1 : t.b;
            o.failed = dz | ov;
            if (t.sgn) begin
               ma = t.a[31] ? -t.a : t.a;
               md = d[31] ? -d : d;
               if (t.op == OP_DIV) begin
                  q = ma / md;
                  o.result = (t.a[31] ^ d[31]) ? -q : q;
               end else begin
                  q = ma % md;
                  o.result = t.a[31] ? -q : q;
               end
            end else begin
               o.result = (t.op == OP_DIV) ? t.a / d : t.a % d;
            end
            o.reason = dz ? RSN_DIVZERO : (ov ? RSN_OVERFLOW : RSN_NONE);
         end
         OP_NEG: begin
            o.result = -t.a;
            o.failed = t.a == 32'h8000_0000;
         end
         OP_PLUS: o.result = t.a;
         OP_NOT:  o.result = ~t.a;
         OP_AND:  o.result = t.a & t.b;
         OP_OR:   o.result = t.a | t.b;
         OP_XOR:  o.result = t.a ^ t.b;
         OP_CMP: begin
            lt = t.sgn ? ($signed(t.a) < $signed(t.b)) : (t.a < t.b);
            gt = t.sgn ? ($signed(t.a) > $signed(t.b)) : (t.a > t.b);
            case (t.pred)
               PRED_EQ: v = t.a == t.b;
               PRED_NE: v = t.a != t.b;
               PRED_LT: v = lt;
               PRED_LE: v = !gt;
               PRED_GT: v = gt;
               default: v = !lt;
            endcase
            o.result = {31'd0, v};
         end
         default: begin
            bad = (t.csgn && t.b[31]) || t.b >= W;
            c = bad ? 0 : int'(t.b);
            ov = 1'b0;
            case (t.op)
               OP_SHLC: begin
                  o.result = t.a << c;
                  ov = ($signed(o.result) >>> c) != $signed(t.a);
               end
               OP_SHL: o.result = t.a << c;
               OP_SRA: o.result = $signed(t.a) >>> c;
               default: o.result = t.a >> c;
            endcase
            o.failed = bad | ov;
            o.reason = bad ? RSN_SHIFT : (ov ? RSN_OVERFLOW : RSN_NONE);
         end
      endcase
      if (t.op <= OP_MUL || t.op == OP_NEG) o.reason = o.failed ? RSN_OVERFLOW : RSN_NONE;
      return o;
   endfunction

   int error_count = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class alu_scoreboard;
      alu_rsp_type pending_results[$];
      int checked;
      function void note_request(alu_req_type t);
         pending_results.push_back(compute_alu(t));
      endfunction
      task check_result(alu_rsp_type got);
         alu_rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", got.result, 32'd0);
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.result !== want.result) report_mismatch("result", got.result, want.result);
         if (got.failed !== want.failed)
            report_mismatch("failed", 32'(got.failed), 32'(want.failed));
         if (got.reason !== want.reason)
            report_mismatch("reason", 32'(got.reason), 32'(want.reason));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   cia_req_if req_ch();
   cia_rsp_if rsp_ch();
   alu_scoreboard board = new();
   int idle_cycles = 0;
   bit stim_done = 0;

   checked_integer_alu_unit uut (.clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch));

   always #5 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request({req_ch.op, req_ch.is_signed, req_ch.left_operand,
                                req_ch.right_operand, req_ch.count_is_signed,
                                req_ch.predicate});
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result({rsp_ch.result, rsp_ch.failed, rsp_ch.reason});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver stalls
   initial begin
      int g;
      rsp_ch.ready = 0;
      @(negedge clock);
      while (1) begin
         g = gap_length();
         rsp_ch.ready <= (g == 0);
         repeat (g == 0 ? $urandom_range(1, 30) : g) @(negedge clock);
      end
   end

   task automatic send_request(alu_req_type t);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.op <= t.op;
      req_ch.is_signed <= t.sgn;
      req_ch.left_operand <= t.a;
      req_ch.right_operand <= t.b;
      req_ch.count_is_signed <= t.csgn;
      req_ch.predicate <= t.pred;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'h7fff_ffff;
         4: return $urandom_range(0, 40);
         5: return -$urandom_range(0, 40);
         6: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      alu_req_type t;
      logic [31:0] edges [4] = '{32'h0, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff};
      req_ch.valid = 0;
      req_ch.op = OP_ADD;
      req_ch.is_signed = 0;
      req_ch.left_operand = 0;
      req_ch.right_operand = 0;
      req_ch.count_is_signed = 0;
      req_ch.predicate = PRED_EQ;
      repeat (10) @(negedge clock);
      reset <= 0;
      // directed: each operation with extreme operands
      for (int k = 0; k < 16; k++) begin
         t = '0;
         t.op = k[3:0];
         t.sgn = k[0];
         t.a = edges[k % 4];
         t.b = edges[(k + 2) % 4];
         t.csgn = 1;
         t.pred = k[2:0];
         send_request(t);
      end
      t = '0; t.op = OP_DIV; t.sgn = 1; t.a = 32'h8000_0000; t.b = 32'hffff_ffff;
      send_request(t);
      t.op = OP_REM; t.b = 0; send_request(t);
      t.op = OP_NEG; t.sgn = 0; send_request(t);
      t.op = OP_SUB; t.a = 1; t.b = 2; send_request(t);
      t.op = OP_SHLC; t.a = 32'h4000_0000; t.b = 1; send_request(t);
      t.op = OP_SRL; t.b = 32; send_request(t);
      t.op = OP_CMP; t.pred = 3'd7; t.a = 3; t.b = 3; send_request(t);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         t.op = 4'($urandom_range(0, 15));
         t.sgn = 1'($urandom_range(0, 1));
         t.a = pick_operand();
         t.b = (t.op >= OP_SHLC && $urandom_range(0, 3) != 0) ?
               32'($urandom_range(0, 33)) : pick_operand();
         t.csgn = 1'($urandom_range(0, 1));
         t.pred = 3'($urandom_range(0, 7));
         send_request(t);
      end
      req_ch.valid <= 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (2 * W + 10) @(posedge clock);
      $display("checked %0d results over all 16 operations, extremes and random operands",
               board.checked);
      if (error_count == 0 && board.pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== sim.f =====
src/cia_pkg.sv
src/cia_req_if.sv
src/cia_rsp_if.sv
src/cia_front.sv
src/cia_cell.sv
src/cia_back.sv
src/checked_integer_alu_unit.sv
tb/sv/tb_checked_integer_alu_unit.sv
